/* rtl/crcal_pkg.sv */
// Shared types and constants for the countdown rate calibrator.
`timescale 1ns / 1ps

package crcal_pkg;

  localparam int unsigned ReadW     = 32;
  localparam int unsigned RateW     = 64;
  localparam int unsigned ReloadW   = 32;
  localparam logic [31:0] RefRateRst = 32'd3579545;

  typedef enum logic [1:0] {
    ST_OK                = 2'd0,
    ST_BAD_FREQUENCY     = 2'd1,
    ST_COUNTER_EXHAUSTED = 2'd2,
    ST_NOT_COUNTING      = 2'd3
  } status_t;

endpackage

/* rtl/crcal_div_cell.sv */
// One restoring-division cell: produces one quotient bit and hands on the rest.
`timescale 1ns / 1ps

module crcal_div_cell #(
  parameter int unsigned DVD_W  = 64,
  parameter int unsigned DIV_W  = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  in_rem,
  input  logic [DVD_W-1:0]  in_dq,
  input  logic [DIV_W-1:0]  in_div,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DIV_W-1:0]  out_rem,
  output logic [DVD_W-1:0]  out_dq,
  output logic [DIV_W-1:0]  out_div,
  output logic [SIDE_W-1:0] out_side
);

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [DIV_W-1:0] rem_next;
  logic [DVD_W-1:0] dq_next;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {in_rem, in_dq[DVD_W-1]};
    diff     = trial - {1'b0, in_div};
    fits     = (trial >= {1'b0, in_div});
    rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    dq_next  = {in_dq[DVD_W-2:0], fits};
  end

  // Hold the beat's valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_rem  <= rem_next;
      out_dq   <= dq_next;
      out_div  <= in_div;
      out_side <= in_side;
    end
  end

endmodule

/* rtl/crcal_div_chain.sv */
// Row of division cells, one quotient bit per cell, one beat per cycle while advance is high.
`timescale 1ns / 1ps

module crcal_div_chain #(
  parameter int unsigned DVD_W  = 64,
  parameter int unsigned DIV_W  = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DVD_W-1:0]  quotient,
  output logic [SIDE_W-1:0] out_side
);

  logic              valid_w [0:DVD_W];
  logic [DIV_W-1:0]  rem_w   [0:DVD_W];
  logic [DVD_W-1:0]  dq_w    [0:DVD_W];
  logic [DIV_W-1:0]  div_w   [0:DVD_W];
  logic [SIDE_W-1:0] side_w  [0:DVD_W];

  // Feed the head of the row
  assign valid_w[0] = in_valid;
  assign rem_w[0]   = '0;
  assign dq_w[0]    = dividend;
  assign div_w[0]   = divisor;
  assign side_w[0]  = in_side;

  // One cell per quotient bit
  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    crcal_div_cell #(
      .DVD_W (DVD_W),
      .DIV_W (DIV_W),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_valid (valid_w[i]),
      .in_rem   (rem_w[i]),
      .in_dq    (dq_w[i]),
      .in_div   (div_w[i]),
      .in_side  (side_w[i]),
      .out_valid(valid_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_dq   (dq_w[i+1]),
      .out_div  (div_w[i+1]),
      .out_side (side_w[i+1])
    );
  end

  assign out_valid = valid_w[DVD_W];
  assign quotient  = dq_w[DVD_W];
  assign out_side  = side_w[DVD_W];

endmodule

/* rtl/countdown_rate_calibrator_unit.sv */
// Top level of the countdown rate calibrator.
`timescale 1ns / 1ps

// Takes one beat per cycle while the row moves and returns one result per beat,
// in order, through the multiply register for the 32x32 multiply, 64 cells for
// the rate division, the rate-check register, 64 cells for the reload division
// and one output register. The whole row of cells moves together and holds
// only while a finished result waits at the output with ready low.
module countdown_rate_calibrator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] start_reading,
  input  logic [31:0] end_reading,
  input  logic [31:0] observed_ref_ticks,
  input  logic [31:0] wanted_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] counter_rate_hz,
  output logic [31:0] reload_count
);

  localparam int unsigned Side1W = 2 + crcal_pkg::ReadW;
  localparam int unsigned Side2W = 2 + crcal_pkg::RateW;

  logic        advance;
  logic [31:0] ref_rate;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_rate <= crcal_pkg::RefRateRst;
    end else if (cfg_wr_en) begin
      ref_rate <= cfg_wr_data;
    end
  end

  // The row moves unless the output holds an untaken result
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Early checks and elapsed count
  crcal_pkg::status_t pre_status;
  logic [31:0]        elapsed;
  always_comb begin
    elapsed = start_reading - end_reading;
    if (ref_rate == '0 || observed_ref_ticks == '0) begin
      pre_status = crcal_pkg::ST_BAD_FREQUENCY;
    end else if (end_reading == '0) begin
      pre_status = crcal_pkg::ST_COUNTER_EXHAUSTED;
    end else if (start_reading <= end_reading) begin
      pre_status = crcal_pkg::ST_NOT_COUNTING;
    end else begin
      pre_status = crcal_pkg::ST_OK;
    end
  end

  // Multiply stage
  logic               mul_valid;
  logic [63:0]        mul_prod;
  logic [31:0]        mul_ticks;
  logic [31:0]        mul_hz;
  crcal_pkg::status_t mul_status;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (advance) begin
      mul_valid <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      mul_prod   <= {32'd0, elapsed} * {32'd0, ref_rate};
      mul_ticks  <= observed_ref_ticks;
      mul_hz     <= wanted_hz;
      mul_status <= pre_status;
    end
  end

  // Rate division
  logic              d1_valid;
  logic [63:0]       d1_quot;
  logic [Side1W-1:0] d1_side;
  crcal_div_chain #(
    .DVD_W (crcal_pkg::RateW),
    .DIV_W (crcal_pkg::ReadW),
    .SIDE_W(Side1W)
  ) u_rate_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (mul_valid),
    .dividend (mul_prod),
    .divisor  (mul_ticks),
    .in_side  ({mul_status, mul_hz}),
    .out_valid(d1_valid),
    .quotient (d1_quot),
    .out_side (d1_side)
  );

  // Rate checks
  crcal_pkg::status_t d1_status;
  crcal_pkg::status_t chk_status_next;
  logic [63:0]        chk_rate_next;
  logic [31:0]        d1_hz;
  always_comb begin
    d1_status       = crcal_pkg::status_t'(d1_side[Side1W-1 -: 2]);
    d1_hz           = d1_side[crcal_pkg::ReadW-1:0];
    chk_status_next = d1_status;
    chk_rate_next   = d1_quot;
    if (d1_status != crcal_pkg::ST_OK) begin
      chk_rate_next = '0;
    end else if (d1_quot == '0) begin
      chk_status_next = crcal_pkg::ST_NOT_COUNTING;
    end else if (d1_hz == '0) begin
      chk_status_next = crcal_pkg::ST_BAD_FREQUENCY;
    end
  end

  logic               chk_valid;
  crcal_pkg::status_t chk_status;
  logic [63:0]        chk_rate;
  logic [31:0]        chk_hz;
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (advance) begin
      chk_valid <= d1_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      chk_status <= chk_status_next;
      chk_rate   <= chk_rate_next;
      chk_hz     <= d1_hz;
    end
  end

  // Reload division
  logic              d2_valid;
  logic [63:0]       d2_quot;
  logic [Side2W-1:0] d2_side;
  crcal_div_chain #(
    .DVD_W (crcal_pkg::RateW),
    .DIV_W (crcal_pkg::ReadW),
    .SIDE_W(Side2W)
  ) u_reload_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (chk_valid),
    .dividend (chk_rate),
    .divisor  (chk_hz),
    .in_side  ({chk_status, chk_rate}),
    .out_valid(d2_valid),
    .quotient (d2_quot),
    .out_side (d2_side)
  );

  // Reload checks
  crcal_pkg::status_t d2_status;
  crcal_pkg::status_t fin_status;
  logic [31:0]        fin_reload;
  always_comb begin
    d2_status  = crcal_pkg::status_t'(d2_side[Side2W-1 -: 2]);
    fin_status = d2_status;
    fin_reload = '0;
    if (d2_status == crcal_pkg::ST_OK) begin
      if (d2_quot == '0 || d2_quot[63:32] != '0) begin
        fin_status = crcal_pkg::ST_BAD_FREQUENCY;
      end else begin
        fin_reload = d2_quot[31:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= d2_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      status          <= fin_status;
      counter_rate_hz <= d2_side[crcal_pkg::RateW-1:0];
      reload_count    <= fin_reload;
    end
  end

  // Any error leaves the reload at zero
  a_err_reload: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != crcal_pkg::ST_OK |-> reload_count == '0)
    else $error("reload nonzero on error");

  // A good result carries a nonzero rate and reload
  a_ok_values: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == crcal_pkg::ST_OK |-> reload_count != '0 && counter_rate_hz != '0)
    else $error("zero value on good result");

  // Rate-step failures report no rate
  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == crcal_pkg::ST_COUNTER_EXHAUSTED ||
                  status == crcal_pkg::ST_NOT_COUNTING) |-> counter_rate_hz == '0)
    else $error("rate reported on rate failure");

endmodule

/* bench/tb_top.sv */
// Testbench for the countdown rate calibrator: random beats checked against a rate predictor.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [31:0] start_rd;
    logic [31:0] end_rd;
    logic [31:0] ticks;
    logic [31:0] hz;
  } calib_req_t;

  typedef struct packed {
    crcal_pkg::status_t st;
    logic [63:0]        rate;
    logic [31:0]        reload;
  } calib_res_t;

  localparam int unsigned PipeLat = 140;
  localparam longint unsigned CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] start_reading = '0;
  logic [31:0] end_reading = '0;
  logic [31:0] observed_ref_ticks = '0;
  logic [31:0] wanted_hz = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] counter_rate_hz;
  logic [31:0] reload_count;

  calib_req_t pending_reqs[$];
  calib_res_t expected_res[$];
  logic [31:0] ref_rate_hz;
  int unsigned fail_cnt = 0;
  longint unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;
  bit          hold_send = 1'b0;

  countdown_rate_calibrator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_reading(start_reading), .end_reading(end_reading),
    .observed_ref_ticks(observed_ref_ticks), .wanted_hz(wanted_hz),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .counter_rate_hz(counter_rate_hz),
    .reload_count(reload_count)
  );

  always #2 clk = ~clk;

  // Compute the expected status, rate and reload for one beat.
  function automatic calib_res_t predict_calibration(calib_req_t r, logic [31:0] ref_hz);
    calib_res_t  res;
    logic [63:0] elapsed;
    logic [63:0] q;
    res = '{crcal_pkg::ST_OK, 64'd0, 32'd0};
    if (ref_hz == 0 || r.ticks == 0) begin
      res.st = crcal_pkg::ST_BAD_FREQUENCY;
    end else if (r.end_rd == 0) begin
      res.st = crcal_pkg::ST_COUNTER_EXHAUSTED;
    end else if (r.start_rd <= r.end_rd) begin
      res.st = crcal_pkg::ST_NOT_COUNTING;
    end else begin
      elapsed = {32'd0, r.start_rd} - {32'd0, r.end_rd};
      res.rate = (elapsed * {32'd0, ref_hz}) / {32'd0, r.ticks};
      if (res.rate == 0) begin
        res.st = crcal_pkg::ST_NOT_COUNTING;
      end else if (r.hz == 0) begin
        res.st = crcal_pkg::ST_BAD_FREQUENCY;
      end else begin
        q = res.rate / {32'd0, r.hz};
        if (q == 0 || q > 64'hFFFF_FFFF) res.st = crcal_pkg::ST_BAD_FREQUENCY;
        else res.reload = q[31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      3: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Build mostly well-formed requests: start above end, small ticks, sane hz.
  function automatic calib_req_t rand_request();
    calib_req_t  r;
    logic [31:0] span;
    if ($urandom_range(0, 9) < 7) begin
      r.end_rd = $urandom_range(1, 32'hFFFF_0000);
      span = $urandom_range(1, 32'hFFFF_FFFF - r.end_rd);
      r.start_rd = r.end_rd + span;
      r.ticks = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 100000);
      r.hz = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(1, 10000);
    end else begin
      r = '{rand_word(), rand_word(), rand_word(), rand_word()};
    end
    return r;
  endfunction

  // Drive beats in bursts with random gaps; hold valid until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready)
        expected_res.push_back(predict_calibration(
          '{start_reading, end_reading, observed_ref_ticks, wanted_hz}, ref_rate_hz));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_send) begin
        calib_req_t r;
        r = pending_reqs.pop_front();
        {start_reading, end_reading, observed_ref_ticks, wanted_hz} <= r;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side on a slow rotating pattern.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) out_ready <= 1'b0;
    else if (stall_phase[9:8] == 2'd0) out_ready <= 1'b1;
    else if (stall_phase[9:8] == 2'd1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 1) != 0);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    calib_res_t exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result status=%0d rate=%0d reload=%0d",
                 $time, status, counter_rate_hz, reload_count);
        fail_cnt <= fail_cnt + 1;
      end else begin
        exp_r = expected_res.pop_front();
        if (status !== exp_r.st || counter_rate_hz !== exp_r.rate ||
            reload_count !== exp_r.reload) begin
          $display({"%0t: mismatch expected st=%0d rate=%0d reload=%0d",
                    " got st=%0d rate=%0d reload=%0d"},
                   $time, exp_r.st, exp_r.rate, exp_r.reload,
                   status, counter_rate_hz, reload_count);
          fail_cnt <= fail_cnt + 1;
        end
      end
    end
  end

  // Stop the run if it hangs.
  always @(posedge clk) begin
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain_all();
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid || expected_res.size() != 0) @(posedge clk);
    repeat (PipeLat) @(posedge clk);
  endtask

  task automatic write_ref_rate(logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    ref_rate_hz <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Queue a phase of random requests after setting the reference rate.
  task automatic run_phase(logic [31:0] rate, int unsigned n);
    write_ref_rate(rate);
    repeat (n) pending_reqs.push_back(rand_request());
    drain_all();
  endtask

  initial begin
    ref_rate_hz = crcal_pkg::RefRateRst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: every status, field extremes, reload overflow and truncation.
    pending_reqs.push_back('{32'd100, 32'd50, 32'd0, 32'd10});
    pending_reqs.push_back('{32'd100, 32'd0, 32'd5, 32'd10});
    pending_reqs.push_back('{32'd50, 32'd100, 32'd5, 32'd10});
    pending_reqs.push_back('{32'd50, 32'd50, 32'd5, 32'd10});
    pending_reqs.push_back('{32'd2, 32'd1, 32'hFFFF_FFFF, 32'd1});
    pending_reqs.push_back('{32'd1000, 32'd1, 32'd100, 32'd0});
    pending_reqs.push_back('{32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1});
    pending_reqs.push_back('{32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF});
    pending_reqs.push_back('{32'd1000, 32'd1, 32'd100, 32'hFFFF_FFFF});
    pending_reqs.push_back('{32'd3579546, 32'd1, 32'd3579545, 32'd100});
    pending_reqs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1, 32'd1});
    pending_reqs.push_back('{32'd0, 32'd0, 32'd0, 32'd0});
    pending_reqs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    drain_all();

    // Random phases across reference rates, including zero and all ones.
    hold_send = 1'b0;
    run_phase(32'd0, 60);
    run_phase(32'hFFFF_FFFF, 250);
    run_phase(32'd1, 120);
    run_phase(32'd3579545, 300);
    run_phase($urandom(), 300);

    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
